### rtl/csl_pkg.sv
// types, constants and helpers shared by the character stream lexer
package csl_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 24;
  localparam int unsigned OFF_OUT_W       = 24;
  localparam int unsigned FIELD_W         = 16;

  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_US  = 8'h5F;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  typedef enum logic [3:0] {
    KIND_EOF    = 4'd0,
    KIND_NUM    = 4'd1,
    KIND_IDENT  = 4'd2,
    KIND_SEMI   = 4'd3,
    KIND_COMMA  = 4'd4,
    KIND_DOT    = 4'd5,
    KIND_LBRACE = 4'd6,
    KIND_RBRACE = 4'd7,
    KIND_LBRACK = 4'd8,
    KIND_RBRACK = 4'd9,
    KIND_LPAREN = 4'd10,
    KIND_RPAREN = 4'd11,
    KIND_ERR    = 4'd12
  } kind_e;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_NUM   = 4'b0010,
    MODE_IDENT = 4'b0100,
    MODE_ERR   = 4'b1000
  } mode_e;

  typedef struct packed {
    kind_e                  kind;
    logic [OFF_OUT_W-1:0]   start_offset;
    logic [FIELD_W-1:0]     token_length;
    logic [FIELD_W-1:0]     line_number;
    logic [FIELD_W-1:0]     column_number;
    logic                   last_of_run;
  } tok_t;

  function automatic logic [FIELD_W-1:0] sat_inc(input logic [FIELD_W-1:0] v);
    sat_inc = (v == '1) ? v : v + FIELD_W'(1);
  endfunction

  function automatic logic is_dec_char(input logic [7:0] c);
    is_dec_char = (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  // KIND_EOF means the byte is not a punctuation mark
  function automatic kind_e mark_kind(input logic [7:0] c);
    unique case (c)
      CH_SEMI:   mark_kind = KIND_SEMI;
      CH_COMMA:  mark_kind = KIND_COMMA;
      CH_DOT:    mark_kind = KIND_DOT;
      CH_LBRACE: mark_kind = KIND_LBRACE;
      CH_RBRACE: mark_kind = KIND_RBRACE;
      CH_LBRACK: mark_kind = KIND_LBRACK;
      CH_RBRACK: mark_kind = KIND_RBRACK;
      CH_LPAREN: mark_kind = KIND_LPAREN;
      CH_RPAREN: mark_kind = KIND_RPAREN;
      default:   mark_kind = KIND_EOF;
    endcase
  endfunction

endpackage

### rtl/char_stream_lexer_top.sv
// character stream lexer: one text byte per transfer in, tokens out
//
// Input channel s_axis: tdata carries one text byte, tlast marks end of
// text (the byte is then ignored). Output channel m_axis: one token per
// transfer, kind in tuser, position fields in tdata, tlast set on the
// final token caused by one input transfer.
// Scanner state is held in registers and updated by short logic in the
// cycle an input transfer is accepted; its tokens (zero, one or two) go
// into a three-entry result queue, whose head entry drives m_axis.
// Throughput: one input transfer per cycle while the receiver keeps up;
// a byte that ends a run and is itself a mark or an unhandled byte, and
// end of text after an open run, give two tokens and so take two output
// transfers. The queue lets an input transfer in while one token still
// waits; the input stalls when two tokens are queued and none leaves,
// and whenever three are queued.
// Reset puts the scanner at line 1, column 0, offset 0 with no open run
// and empties the queue; end of text restarts the scanner the same way
// after its end-of-file token but keeps the queue, so the next text may follow.
// When the receiver stalls, the head token holds on m_axis.
module char_stream_lexer_top #(
  parameter int unsigned OffsetBits = csl_pkg::OFFSET_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // ch
  input  logic                         s_axis_tlast,   // end_of_text
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // start_offset[23:0], token_length[39:24], line_number[55:40],
  // column_number[71:56]
  output logic [71:0]                  m_axis_tdata,
  output csl_pkg::kind_e               m_axis_tuser,   // kind
  output logic                         m_axis_tlast    // last_of_run
);
  import csl_pkg::*;

  localparam int unsigned ExtW = (OffsetBits > OFF_OUT_W) ? OffsetBits : OFF_OUT_W;

  mode_e                  mode_q, mode_d;
  logic [OffsetBits-1:0]  run_start_q, run_start_d;
  logic [FIELD_W-1:0]     run_len_q, run_len_d;
  logic [FIELD_W-1:0]     run_col_q, run_col_d;
  logic [FIELD_W-1:0]     line_q, line_d;
  logic [FIELD_W-1:0]     col_q, col_d;
  logic [OffsetBits-1:0]  pos_q, pos_d;

  tok_t                   q_q [3];
  tok_t                   q_d [3];
  logic [1:0]             cnt_q, cnt_d;
  logic [1:0]             base;

  logic                   s_acc, pop;
  logic                   in_run, cont, word_ch;
  logic                   a_vld, b_vld;
  tok_t                   tok_a, tok_b;
  kind_e                  mk;
  logic [ExtW-1:0]        pos_ext, start_ext;

  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign pop     = m_axis_tvalid && m_axis_tready;
  assign pos_ext   = ExtW'(pos_q);
  assign start_ext = ExtW'(run_start_q);
  assign mk      = mark_kind(s_axis_tdata);
  assign word_ch = is_dec_char(s_axis_tdata) || is_letter(s_axis_tdata) ||
                   (s_axis_tdata == CH_US);

  always_comb begin
    in_run = 1'b0;
    cont   = 1'b0;
    unique case (mode_q)
      MODE_NUM: begin
        in_run = 1'b1;
        cont   = !s_axis_tlast && (is_dec_char(s_axis_tdata) || s_axis_tdata == CH_US);
      end
      MODE_IDENT: begin
        in_run = 1'b1;
        cont   = !s_axis_tlast && word_ch;
      end
      MODE_IDLE, MODE_ERR: begin
        in_run = 1'b0;
      end
      default: begin
        in_run = 1'b0;
      end
    endcase
  end

  // scanner next state and the tokens of the accepted byte
  always_comb begin
    mode_d      = mode_q;
    run_start_d = run_start_q;
    run_len_d   = run_len_q;
    run_col_d   = run_col_q;
    line_d      = line_q;
    col_d       = col_q;
    pos_d       = pos_q;
    a_vld       = 1'b0;
    b_vld       = 1'b0;
    tok_a       = '0;
    tok_b       = '0;
    if (s_acc) begin
      if (in_run && cont) begin
        run_len_d = sat_inc(run_len_q);
        pos_d     = pos_q + OffsetBits'(1);
        col_d     = sat_inc(col_q);
      end else begin
        if (in_run) begin
          a_vld               = 1'b1;
          tok_a.kind          = (mode_q == MODE_NUM) ? KIND_NUM : KIND_IDENT;
          tok_a.start_offset  = start_ext[OFF_OUT_W-1:0];
          tok_a.token_length  = run_len_q;
          tok_a.line_number   = line_q;
          tok_a.column_number = run_col_q;
          mode_d              = MODE_IDLE;
        end
        if (s_axis_tlast) begin
          b_vld               = 1'b1;
          tok_b.kind          = KIND_EOF;
          tok_b.start_offset  = pos_ext[OFF_OUT_W-1:0];
          tok_b.token_length  = '0;
          tok_b.line_number   = line_q;
          tok_b.column_number = col_q;
          mode_d              = MODE_IDLE;
          run_start_d         = '0;
          run_len_d           = '0;
          run_col_d           = '0;
          line_d              = FIELD_W'(1);
          col_d               = '0;
          pos_d               = '0;
        end else if (mode_q == MODE_ERR) begin
          // skipping to end of text
          mode_d = MODE_ERR;
        end else if (s_axis_tdata == CH_NL) begin
          pos_d  = pos_q + OffsetBits'(1);
          line_d = sat_inc(line_q);
          col_d  = '0;
        end else if (s_axis_tdata == CH_SP) begin
          pos_d = pos_q + OffsetBits'(1);
          col_d = sat_inc(col_q);
        end else if (word_ch) begin
          mode_d      = is_dec_char(s_axis_tdata) ? MODE_NUM : MODE_IDENT;
          run_start_d = pos_q;
          run_len_d   = FIELD_W'(1);
          run_col_d   = col_q;
          pos_d       = pos_q + OffsetBits'(1);
          col_d       = sat_inc(col_q);
        end else begin
          b_vld               = 1'b1;
          tok_b.start_offset  = pos_ext[OFF_OUT_W-1:0];
          tok_b.token_length  = FIELD_W'(1);
          tok_b.line_number   = line_q;
          tok_b.column_number = col_q;
          if (mk != KIND_EOF) begin
            tok_b.kind = mk;
            pos_d      = pos_q + OffsetBits'(1);
            col_d      = sat_inc(col_q);
          end else begin
            tok_b.kind = KIND_ERR;
            mode_d     = MODE_ERR;
          end
        end
      end
    end
    tok_a.last_of_run = !b_vld;
    tok_b.last_of_run = 1'b1;
  end

  // result queue: head at entry 0, shifts down on each output transfer
  always_comb begin
    q_d = q_q;
    if (pop) begin
      q_d[0] = q_q[1];
      q_d[1] = q_q[2];
    end
    base = cnt_q - {1'b0, pop};
    if (a_vld) begin
      q_d[base] = tok_a;
    end
    if (b_vld) begin
      q_d[base + {1'b0, a_vld}] = tok_b;
    end
    cnt_d = base + {1'b0, a_vld} + {1'b0, b_vld};
  end

  assign s_axis_tready = (cnt_q <= 2'd1) || ((cnt_q == 2'd2) && m_axis_tready);
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = {q_q[0].column_number, q_q[0].line_number,
                          q_q[0].token_length, q_q[0].start_offset};
  assign m_axis_tuser  = q_q[0].kind;
  assign m_axis_tlast  = q_q[0].last_of_run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      run_start_q <= '0;
      run_len_q   <= '0;
      run_col_q   <= '0;
      line_q      <= FIELD_W'(1);
      col_q       <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
    end else begin
      mode_q      <= mode_d;
      run_start_q <= run_start_d;
      run_len_q   <= run_len_d;
      run_col_q   <= run_col_d;
      line_q      <= line_d;
      col_q       <= col_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  a_eot_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && s_axis_tlast) |=> (mode_q == MODE_IDLE && line_q == FIELD_W'(1) &&
                                 col_q == '0 && pos_q == '0))
    else $error("scanner not restarted after end of text");

  a_eof_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_EOF) |-> m_axis_tlast)
    else $error("end-of-file token without tlast");

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0)
    else $error("line count reached zero");

  a_run_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_NUM || mode_q == MODE_IDENT) |-> (run_len_q != '0))
    else $error("open run with zero length");

endmodule

### dv/char_stream_lexer_top_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the character stream lexer: byte stream in, tokens checked on the fly
module char_stream_lexer_top_tb;
  import csl_pkg::*;

  localparam int unsigned POS_W = OFFSET_BITS_DEF;
  localparam int unsigned RANDOM_BYTES = 1520;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } text_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // start_offset, token_length, line_number, column_number
  logic [71:0] m_axis_tdata;
  kind_e       m_axis_tuser;   // kind
  logic        m_axis_tlast;   // last_of_run

  char_stream_lexer_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  text_byte_t text_bytes[$];
  tok_t       expected_tokens[$];
  int         err_cnt = 0;
  longint     n_total = 0;
  longint     n_accepted = 0;
  longint     cycle_cnt = 0;
  longint     cycle_limit = 64'd1_000_000_000;

  // scanner copy kept by the bench
  mode_e             sc_mode;
  logic [POS_W-1:0]  sc_run_start;
  logic [15:0]       sc_run_len;
  logic [15:0]       sc_run_col;
  logic [15:0]       sc_line;
  logic [15:0]       sc_col;
  logic [POS_W-1:0]  sc_pos;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] sat16(input logic [15:0] v);
    return (&v) ? v : v + 16'd1;
  endfunction

  function automatic logic digit_byte(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic alpha_byte(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic kind_e punct_kind(input logic [7:0] c);
    case (c)
      CH_SEMI:   return KIND_SEMI;
      CH_COMMA:  return KIND_COMMA;
      CH_DOT:    return KIND_DOT;
      CH_LBRACE: return KIND_LBRACE;
      CH_RBRACE: return KIND_RBRACE;
      CH_LBRACK: return KIND_LBRACK;
      CH_RBRACK: return KIND_RBRACK;
      CH_LPAREN: return KIND_LPAREN;
      CH_RPAREN: return KIND_RPAREN;
      default:   return KIND_ERR;
    endcase
  endfunction

  task automatic clear_scanner();
    sc_mode      = MODE_IDLE;
    sc_run_start = '0;
    sc_run_len   = '0;
    sc_run_col   = '0;
    sc_line      = 16'd1;
    sc_col       = '0;
    sc_pos       = '0;
  endtask

  task automatic step_column();
    sc_pos = sc_pos + 1'b1;
    sc_col = sat16(sc_col);
  endtask

  task automatic add_token(input kind_e k, input logic [POS_W-1:0] off,
                           input logic [15:0] len, input logic [15:0] line,
                           input logic [15:0] col);
    tok_t t;
    t.kind          = k;
    t.start_offset  = off[OFF_OUT_W-1:0];
    t.token_length  = len;
    t.line_number   = line;
    t.column_number = col;
    t.last_of_run   = 1'b0;
    expected_tokens.push_back(t);
  endtask

  // tokens caused by one accepted byte
  task automatic lex_byte(input logic [7:0] c, input logic eot);
    int    n0;
    logic  cont;
    kind_e mk;
    n0 = expected_tokens.size();
    if (sc_mode == MODE_NUM || sc_mode == MODE_IDENT) begin
      cont = !eot && (digit_byte(c) || c == CH_US || (sc_mode == MODE_IDENT && alpha_byte(c)));
      if (cont) begin
        sc_run_len = sat16(sc_run_len);
        step_column();
        return;
      end
      add_token(sc_mode == MODE_NUM ? KIND_NUM : KIND_IDENT, sc_run_start, sc_run_len,
                sc_line, sc_run_col);
      sc_mode = MODE_IDLE;
    end
    if (eot) begin
      add_token(KIND_EOF, sc_pos, 16'd0, sc_line, sc_col);
      clear_scanner();
    end else if (sc_mode != MODE_ERR) begin
      mk = punct_kind(c);
      if (c == CH_NL) begin
        sc_pos  = sc_pos + 1'b1;
        sc_line = sat16(sc_line);
        sc_col  = '0;
      end else if (c == CH_SP) begin
        step_column();
      end else if (digit_byte(c) || alpha_byte(c) || c == CH_US) begin
        sc_mode      = digit_byte(c) ? MODE_NUM : MODE_IDENT;
        sc_run_start = sc_pos;
        sc_run_len   = 16'd1;
        sc_run_col   = sc_col;
        step_column();
      end else if (mk != KIND_ERR) begin
        add_token(mk, sc_pos, 16'd1, sc_line, sc_col);
        step_column();
      end else begin
        add_token(KIND_ERR, sc_pos, 16'd1, sc_line, sc_col);
        sc_mode = MODE_ERR;
      end
    end
    if (expected_tokens.size() > n0) expected_tokens[$].last_of_run = 1'b1;
  endtask

  task automatic push_byte(input logic [7:0] c);
    text_bytes.push_back('{ch: c, eot: 1'b0});
  endtask

  task automatic push_end(input logic [7:0] c);
    text_bytes.push_back('{ch: c, eot: 1'b1});
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 10) return 8'(8'h30 + r);
    if (r < 36) return 8'(8'h41 + r - 10);
    if (r < 62) return 8'(8'h61 + r - 36);
    return CH_US;
  endfunction

  function automatic logic [7:0] rand_ident_head();
    logic [7:0] c;
    c = rand_word_char();
    while (digit_byte(c)) c = rand_word_char();
    return c;
  endfunction

  function automatic logic [7:0] rand_mark();
    case ($urandom_range(0, 8))
      0: return CH_SEMI;
      1: return CH_COMMA;
      2: return CH_DOT;
      3: return CH_LBRACE;
      4: return CH_RBRACE;
      5: return CH_LBRACK;
      6: return CH_RBRACK;
      7: return CH_LPAREN;
      default: return CH_RPAREN;
    endcase
  endfunction

  // mostly well-formed tokens packed with or without separators, some noise
  task automatic add_text();
    int ntok;
    int sel;
    int len;
    ntok = $urandom_range(1, 20);
    for (int i = 0; i < ntok; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 28) begin
        push_byte(rand_ident_head());
        len = $urandom_range(0, 6);
        repeat (len) push_byte(rand_word_char());
      end else if (sel < 48) begin
        push_byte(8'(8'h30 + $urandom_range(0, 9)));
        len = $urandom_range(0, 5);
        repeat (len) begin
          if ($urandom_range(0, 10) == 10) push_byte(CH_US);
          else push_byte(8'(8'h30 + $urandom_range(0, 9)));
        end
      end else if (sel < 70) begin
        push_byte(rand_mark());
      end else if (sel < 84) begin
        push_byte(CH_SP);
      end else if (sel < 97) begin
        push_byte(CH_NL);
      end else if (sel < 99) begin
        push_byte(8'($urandom_range(0, 255)));
      end else begin
        push_byte(8'h2B);
      end
    end
    if ($urandom_range(0, 9) != 0) push_end(8'($urandom_range(0, 255)));
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // sender: bursts of transfers with random gaps, valid held until accepted
  text_byte_t tx_item;
  int         tx_burst = 1;
  int         tx_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        lex_byte(s_axis_tdata, s_axis_tlast);
        n_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0 || text_bytes.size() == 0) begin
          s_axis_tvalid <= 1'b0;
          if (tx_gap > 0) tx_gap <= tx_gap - 1;
        end else begin
          tx_item = text_bytes.pop_front();
          s_axis_tdata  <= tx_item.ch;
          s_axis_tlast  <= tx_item.eot;
          s_axis_tvalid <= 1'b1;
          if (tx_burst <= 1) begin
            tx_burst <= $urandom_range(1, 48);
            tx_gap   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            tx_burst <= tx_burst - 1;
          end
        end
      end
    end
  end

  // receiver: stall style picked anew whenever the 7-bit tick counter wraps
  int         rx_mode = 0;
  logic [6:0] rx_tick = '0;
  int         rx_hold = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      rx_tick <= rx_tick + 1'b1;
      if (rx_tick == '0) rx_mode <= $urandom_range(0, 3);
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 7) != 0);
        default: begin
          if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
          end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rx_hold <= $urandom_range(1, 12);
          end
        end
      endcase
    end
  end

  // compare each token transfer with the oldest expected token
  tok_t want;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_tokens.size() == 0) begin
        $error("token with none expected: kind %0d offset %0d", m_axis_tuser,
               m_axis_tdata[23:0]);
        err_cnt++;
      end else begin
        want = expected_tokens.pop_front();
        check_field("kind", want.kind, m_axis_tuser);
        check_field("start_offset", want.start_offset, m_axis_tdata[23:0]);
        check_field("token_length", want.token_length, m_axis_tdata[39:24]);
        check_field("line_number", want.line_number, m_axis_tdata[55:40]);
        check_field("column_number", want.column_number, m_axis_tdata[71:56]);
        check_field("last_of_run", want.last_of_run, m_axis_tlast);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > cycle_limit) begin
      $display("char_stream_lexer_top_tb failed");
      $finish;
    end
  end

  initial begin
    int base;
    clear_scanner();

    // idents, numbers, every mark, newline, flush of an open run at end of text
    push_str("_Zz9 0_;x,.{}[]()\nA1");
    push_end(8'hFF);
    // number cut by a letter, ident cut by plus: two tokens from one byte
    push_str("0a+");
    push_end(8'h00);
    // byte zero is an error, then the rest is skipped
    push_byte(8'h00);
    push_byte(8'hFF);
    push_end(8'h5A);

    base = text_bytes.size();
    while (text_bytes.size() - base < RANDOM_BYTES) add_text();
    push_end(8'h00);

    n_total = text_bytes.size();
    // slowest case: gap, two tokens each behind a long stall, then a wide margin
    cycle_limit = 200 * n_total + 20000;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < n_total) @(posedge clk_i);
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("char_stream_lexer_top_tb passed");
    end else begin
      $display("char_stream_lexer_top_tb failed");
    end
    $finish;
  end

endmodule
